### hdl/bcd_converter_assert.svh
// ----------------------------------------------------------------------------
// bcd_converter_assert.svh
// Assertion macros used by the converter's digit cell RTL.
// ----------------------------------------------------------------------------
`ifndef BCD_CONVERTER_ASSERT_SVH
`define BCD_CONVERTER_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define BCDC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcd converter assertion failed");

// next-cycle implication
`define BCDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcd converter assertion failed");

`endif

### hdl/bcdc_pkg.sv
// ----------------------------------------------------------------------------
// bcdc_pkg
// Types, constants and elaboration helpers for the BCD converter.
// ----------------------------------------------------------------------------
package bcdc_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int WORD_W      = 32;
    localparam int NIB_W       = 4;
    localparam int NIBBLES     = WORD_W / NIB_W;
    localparam int SLOT_W      = $clog2(NIBBLES);
    localparam int WIDE_W      = 64;
    localparam int DIGIT_MAX   = 9;

    localparam logic OP_TO_BCD = 1'b0;
    localparam logic OP_TO_BIN = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [WORD_W-1:0] value;
    } bcdc_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              error;
    } bcdc_out_t;

    // item as it travels along the chain
    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] packed_bcd;
        logic              err;
    } bcdc_stage_t;

    // per-cell constants: multiples of the cell's decimal weight, nibble slot and in-word flag
    typedef struct packed {
        logic [DIGIT_MAX:1][WIDE_W-1:0] mult;
        logic [SLOT_W-1:0]              slot;
        logic                           in_word;
    } bcdc_cell_cfg_t;

    function automatic logic [WIDE_W-1:0] pow10(input int k);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(1);
        for (int i = 0; i < k; i++)
        begin
            w = w * WIDE_W'(10);
        end
        return w;
    endfunction

    function automatic bcdc_cell_cfg_t cell_cfg(input int k);
        bcdc_cell_cfg_t c;
        logic [WIDE_W-1:0] w;
        w = pow10(k);
        for (int q = 1; q <= DIGIT_MAX; q++)
        begin
            c.mult[q] = w * WIDE_W'(q);
        end
        c.in_word = (k < NIBBLES);
        c.slot    = (k < NIBBLES) ? SLOT_W'(k) : '0;
        return c;
    endfunction

    localparam logic [WIDE_W-1:0] BIN_LIMIT = pow10(DIGIT_COUNT);

endpackage

### hdl/bcd_converter.sv
// Path: each request is registered in every digit cell of the chain in turn before the response is valid.
// Throughput: one item per cycle while the response is not stalled; one register per digit cell in the chain.
// A stalled response holds the chain; each cell keeps taking items while it has room.
// Reset: rst_n clears all cell valid flags; no other state.
// ----------------------------------------------------------------------------
// bcd_converter
// Two-way 8-digit packed BCD converter built as a pipelined chain of digit cells.
// ----------------------------------------------------------------------------
module bcd_converter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  bcdc_pkg::bcdc_in_t req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output bcdc_pkg::bcdc_out_t rsp_data
);

    bcdc_pkg::bcdc_stage_t chain [0:bcdc_pkg::DIGIT_COUNT];
    logic                  valid [0:bcdc_pkg::DIGIT_COUNT];
    logic                  stall [0:bcdc_pkg::DIGIT_COUNT];
    bcdc_pkg::bcdc_stage_t entry;

    // entry: range check for binary input, seed remainder or accumulator
    always_comb
    begin
        entry.op         = req_data.operation;
        entry.value      = req_data.value;
        entry.packed_bcd = '0;
        entry.rem        = (req_data.operation == bcdc_pkg::OP_TO_BCD) ? req_data.value : '0;
        entry.err        = (req_data.operation == bcdc_pkg::OP_TO_BCD)
                        && ({{(bcdc_pkg::WIDE_W - bcdc_pkg::WORD_W){1'b0}}, req_data.value}
                            >= bcdc_pkg::BIN_LIMIT);
    end

    assign chain[0]  = entry;
    assign valid[0]  = req_valid;
    assign req_stall = stall[0];

    // most significant digit first
    for (genvar i = 0; i < bcdc_pkg::DIGIT_COUNT; i++)
    begin : g_cell
        localparam bcdc_pkg::bcdc_cell_cfg_t CELL_CFG =
            bcdc_pkg::cell_cfg(bcdc_pkg::DIGIT_COUNT - 1 - i);

        bcdc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (CELL_CFG),
            .up_valid (valid[i]),
            .up_stall (stall[i]),
            .up_data  (chain[i]),
            .dn_valid (valid[i+1]),
            .dn_stall (stall[i+1]),
            .dn_data  (chain[i+1])
        );
    end

    assign stall[bcdc_pkg::DIGIT_COUNT] = rsp_stall;
    assign rsp_valid = valid[bcdc_pkg::DIGIT_COUNT];

    always_comb
    begin
        rsp_data.error = chain[bcdc_pkg::DIGIT_COUNT].err;
        if (chain[bcdc_pkg::DIGIT_COUNT].err)
        begin
            rsp_data.result = '1;
        end
        else if (chain[bcdc_pkg::DIGIT_COUNT].op == bcdc_pkg::OP_TO_BIN)
        begin
            rsp_data.result = chain[bcdc_pkg::DIGIT_COUNT].rem;
        end
        else
        begin
            rsp_data.result = chain[bcdc_pkg::DIGIT_COUNT].packed_bcd;
        end
    end

endmodule

### hdl/bcdc_cell.sv
// ----------------------------------------------------------------------------
// bcdc_cell
// One decimal digit of the converter chain, with its own pipeline register.
// ----------------------------------------------------------------------------
`include "bcd_converter_assert.svh"

module bcdc_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bcdc_pkg::bcdc_cell_cfg_t cfg,
    input  logic                    up_valid,
    output logic                    up_stall,
    input  bcdc_pkg::bcdc_stage_t   up_data,
    output logic                    dn_valid,
    input  logic                    dn_stall,
    output bcdc_pkg::bcdc_stage_t   dn_data
);

    logic                  valid_reg;
    logic                  valid_next;
    bcdc_pkg::bcdc_stage_t data_reg;
    bcdc_pkg::bcdc_stage_t data_next;
    logic                  load;

    logic [bcdc_pkg::NIB_W-1:0]  digit;
    logic [bcdc_pkg::WORD_W-1:0] sub;
    logic [bcdc_pkg::NIB_W-1:0]  nib;
    logic [bcdc_pkg::WORD_W-1:0] times_ten;

    logic                        bcd_live;
    logic [bcdc_pkg::WIDE_W-1:0] rem_wide;

    assign up_stall   = valid_reg && dn_stall;
    assign load       = up_valid && !up_stall;
    assign valid_next = up_stall ? valid_reg : up_valid;

    // digit select: largest multiple not above the remainder
    always_comb
    begin
        digit = '0;
        sub   = '0;
        for (int q = 1; q <= bcdc_pkg::DIGIT_MAX; q++)
        begin
            if ({{(bcdc_pkg::WIDE_W - bcdc_pkg::WORD_W){1'b0}}, up_data.rem} >= cfg.mult[q])
            begin
                digit = bcdc_pkg::NIB_W'(q);
                sub   = cfg.mult[q][bcdc_pkg::WORD_W-1:0];
            end
        end
    end

    assign nib = cfg.in_word ? up_data.value[{cfg.slot, 2'b00} +: bcdc_pkg::NIB_W] : '0;
    assign times_ten = {up_data.rem[bcdc_pkg::WORD_W-4:0], 3'b000}
                     + {up_data.rem[bcdc_pkg::WORD_W-2:0], 1'b0}
                     + {{(bcdc_pkg::WORD_W - bcdc_pkg::NIB_W){1'b0}}, nib};

    always_comb
    begin
        data_next = up_data;
        unique case (up_data.op)
            bcdc_pkg::OP_TO_BCD:
            begin
                data_next.rem = up_data.rem - sub;
                if (cfg.in_word)
                begin
                    data_next.packed_bcd[{cfg.slot, 2'b00} +: bcdc_pkg::NIB_W] = digit;
                end
                else if (digit != '0)
                begin
                    data_next.err = 1'b1;
                end
            end
            bcdc_pkg::OP_TO_BIN:
            begin
                data_next.rem = times_ten;
                if (nib > bcdc_pkg::NIB_W'(bcdc_pkg::DIGIT_MAX))
                begin
                    data_next.err = 1'b1;
                end
            end
            default:
            begin
                data_next = up_data;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    assign bcd_live = dn_valid && dn_data.op == bcdc_pkg::OP_TO_BCD && !dn_data.err;
    assign rem_wide = {{(bcdc_pkg::WIDE_W - bcdc_pkg::WORD_W){1'b0}}, dn_data.rem};

    `BCDC_ASSERT_IMPL(a_rem_below_weight, bcd_live, rem_wide < cfg.mult[1])
    `BCDC_ASSERT_NEXT(a_load_fills, up_valid && !up_stall, dn_valid)
    `BCDC_ASSERT_NEXT(a_err_sticks, up_valid && !up_stall && up_data.err, dn_data.err)

endmodule
